// ----- sv/bba_pkg.sv -----
// shared types, constants and helpers for the buddy block allocator
package bba_pkg;

    localparam int ORDER_LIMIT  = 16;
    localparam int HEADER_BYTES = 16;
    localparam int MIN_ORDER    = 5;
    localparam int SLOT_COUNT   = 2048;
    localparam int SLOT_W       = $clog2(SLOT_COUNT);
    localparam int SCNT_W       = SLOT_W + 1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_MEM   = 2'd1;
    localparam logic [1:0] ST_BAD_FREE = 2'd2;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef struct packed {
        logic [4:0] order;
        logic       free;
        logic       head;
    } t_slot;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_A_RD,
        S_A_EV,
        S_A_SPLIT,
        S_F_RD,
        S_F_CHK,
        S_F_MRG,
        S_F_BCHK,
        S_F_FIN
    } t_state;

    // slots covered by a block of the given order
    function automatic logic [SCNT_W-1:0] slot_span(input logic [4:0] ord);
        logic [SCNT_W-1:0] r;
        if (ord <= 5'(MIN_ORDER)) begin
            r = SCNT_W'(1);
        end else begin
            r = SCNT_W'(1) << (ord - 5'(MIN_ORDER));
        end
        return r;
    endfunction

    function automatic logic [4:0] clamp_order(input logic [4:0] v);
        logic [4:0] r;
        if (v < 5'(MIN_ORDER)) begin
            r = 5'(MIN_ORDER);
        end else if (v > 5'(ORDER_LIMIT)) begin
            r = 5'(ORDER_LIMIT);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ----- sv/bba_req_if.sv -----
// request and response channel interfaces
interface bba_req_if import bba_pkg::*; ();
    logic        valid;
    logic        ready;
    logic        func;
    logic [16:0] size_bytes;
    logic [15:0] user_offset_in;

    modport source(output valid, func, size_bytes, user_offset_in, input ready);
    modport sink(input valid, func, size_bytes, user_offset_in, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] user_offset_out;
    logic [4:0]  granted_order;

    modport source(output valid, status, user_offset_out, granted_order, input ready);
    modport sink(input valid, status, user_offset_out, granted_order, output ready);
endinterface

// ----- sv/buddy_block_allocator_unit.sv -----
// buddy allocator top level: slot store, scan, split and merge sequencer
//
//  channel | dir | handshake    | payload
//  i_req   | in  | valid/ready  | func, size_bytes, user_offset_in
//  o_rsp   | out | valid/ready  | status, user_offset_out, granted_order
//  i_cfg   | in  | write enable | region_order
//
// alloc: the slot scan reads, then evaluates, each block head (S_A_RD, S_A_EV) for
// up to 2048 heads, then S_A_SPLIT splits once per level; free: S_F_RD, S_F_CHK,
// then S_F_MRG and S_F_BCHK per merge level, then S_F_FIN. the slot memory port
// does one read and one write per cycle. after reset and after every region_order
// write a clearing pass over all 2048 slots runs before requests are taken; one
// request is in work at a time, the next taken once the previous response has left.
module buddy_block_allocator_unit import bba_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [4:0]   i_cfg_wdata,
    bba_req_if.sink      i_req,
    bba_rsp_if.source    o_rsp
);
    t_slot mem [SLOT_COUNT];
    t_slot r_rdata;

    t_state r_state, n_state;
    logic [4:0]        r_region_order;
    logic [SLOT_W-1:0] r_cnt, n_cnt;
    logic [SCNT_W-1:0] r_s, n_s;
    logic [SLOT_W-1:0] r_best, n_best;
    logic [SLOT_W-1:0] r_b, n_b;
    logic [4:0]        r_bord, n_bord;
    logic              r_found, n_found;
    logic [4:0]        r_k, n_k;
    logic [4:0]        r_o, n_o;
    logic [4:0]        r_first, n_first;
    logic              r_out_valid, n_out_valid;
    logic [1:0]        r_out_status, n_out_status;
    logic [15:0]       r_out_off, n_out_off;
    logic [4:0]        r_out_ord, n_out_ord;

    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    t_slot             wr_data;
    logic [SLOT_W-1:0] rd_addr;

    logic [4:0]        calc_k;
    logic              calc_fit;
    logic [SCNT_W-1:0] nslots;
    logic              accept;
    logic [15:0]       free_addr;
    logic [SLOT_W-1:0] free_slot;
    logic              hit;
    logic [SCNT_W:0]   next_s;
    logic [4:0]        split_ord;
    logic [SCNT_W:0]   split_b;
    logic [SCNT_W-1:0] span_o;
    logic [SLOT_W-1:0] buddy;

    bba_order_calc u_order (
        .i_size_bytes  (i_req.size_bytes),
        .i_region_order(r_region_order),
        .o_order       (calc_k),
        .o_fit         (calc_fit)
    );

    assign nslots      = slot_span(r_region_order);
    assign i_req.ready = (r_state == S_IDLE) && !r_out_valid;
    assign accept      = i_req.valid && i_req.ready;
    assign free_addr   = i_req.user_offset_in - 16'(HEADER_BYTES);
    assign free_slot   = free_addr[15:MIN_ORDER];

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_out_status;
    assign o_rsp.user_offset_out = r_out_off;
    assign o_rsp.granted_order   = r_out_ord;

    // slot store, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rdata <= mem[rd_addr];
    end

    // scan candidate test folds in the slot just read
    assign hit = r_rdata.head && r_rdata.free && (r_rdata.order >= r_k) &&
                 (!r_found || r_rdata.order < r_bord);
    assign next_s    = {1'b0, r_s} + {1'b0, slot_span(r_rdata.order)};
    assign split_ord = r_bord - 5'd1;
    assign split_b   = (SCNT_W+1)'(r_best) + {1'b0, slot_span(split_ord)};
    assign span_o    = slot_span(r_o);
    assign buddy     = r_s[SLOT_W-1:0] ^ span_o[SLOT_W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:   if (r_cnt == SLOT_W'(SLOT_COUNT - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (accept) begin
                    if (i_req.func == FUNC_ALLOC) begin
                        if (calc_fit) n_state = S_A_RD;
                    end else if (i_req.user_offset_in >= 16'(HEADER_BYTES) &&
                                 free_addr[MIN_ORDER-1:0] == '0 &&
                                 SCNT_W'(free_slot) < nslots) begin
                        n_state = S_F_RD;
                    end
                end
            end
            S_A_RD:    n_state = S_A_EV;
            S_A_EV: begin
                if (next_s >= {1'b0, nslots}) begin
                    n_state = (hit || r_found) ? S_A_SPLIT : S_IDLE;
                end else begin
                    n_state = S_A_RD;
                end
            end
            S_A_SPLIT: if (r_bord <= r_k) n_state = S_IDLE;
            S_F_RD:    n_state = S_F_CHK;
            S_F_CHK:   n_state = (!r_rdata.head || r_rdata.free) ? S_IDLE : S_F_MRG;
            S_F_MRG: begin
                if (r_o >= r_region_order || SCNT_W'(buddy) >= nslots) begin
                    n_state = S_F_FIN;
                end else begin
                    n_state = S_F_BCHK;
                end
            end
            S_F_BCHK: begin
                if (r_rdata.head && r_rdata.free && r_rdata.order == r_o) begin
                    n_state = S_F_MRG;
                end else begin
                    n_state = S_F_FIN;
                end
            end
            S_F_FIN:   n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
        if (i_cfg_we) n_state = S_CLEAR;
    end

    // datapath and outputs
    always_comb begin
        n_cnt        = r_cnt;
        n_s          = r_s;
        n_best       = r_best;
        n_b          = r_b;
        n_bord       = r_bord;
        n_found      = r_found;
        n_k          = r_k;
        n_o          = r_o;
        n_first      = r_first;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_off    = r_out_off;
        n_out_ord    = r_out_ord;
        wr_en        = 1'b0;
        wr_addr      = r_cnt;
        wr_data      = '0;
        rd_addr      = r_s[SLOT_W-1:0];
        case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_cnt;
                if (r_cnt == '0) begin
                    wr_data = '{order: r_region_order, free: 1'b1, head: 1'b1};
                end
                n_cnt = r_cnt + SLOT_W'(1);
            end
            S_IDLE: begin
                if (accept) begin
                    n_out_off = '0;
                    n_out_ord = '0;
                    if (i_req.func == FUNC_ALLOC) begin
                        n_k     = calc_k;
                        n_s     = '0;
                        n_found = 1'b0;
                        if (!calc_fit) begin
                            n_out_valid  = 1'b1;
                            n_out_status = ST_NO_MEM;
                        end
                    end else begin
                        n_s = SCNT_W'(free_slot);
                        if (!(i_req.user_offset_in >= 16'(HEADER_BYTES) &&
                              free_addr[MIN_ORDER-1:0] == '0 &&
                              SCNT_W'(free_slot) < nslots)) begin
                            n_out_valid  = 1'b1;
                            n_out_status = ST_BAD_FREE;
                        end
                    end
                end
            end
            S_A_EV: begin
                if (hit) begin
                    n_found = 1'b1;
                    n_best  = r_s[SLOT_W-1:0];
                    n_bord  = r_rdata.order;
                end
                n_s = next_s[SCNT_W-1:0];
                if (next_s >= {1'b0, nslots} && !(hit || r_found)) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_NO_MEM;
                    n_out_off    = '0;
                    n_out_ord    = '0;
                end
            end
            S_A_SPLIT: begin
                if (r_bord > r_k) begin
                    // upper half becomes a free block of one order less
                    n_bord  = split_ord;
                    wr_en   = split_b < (SCNT_W+1)'(nslots);
                    wr_addr = split_b[SLOT_W-1:0];
                    wr_data = '{order: split_ord, free: 1'b1, head: 1'b1};
                end else begin
                    wr_en        = 1'b1;
                    wr_addr      = r_best;
                    wr_data      = '{order: r_k, free: 1'b0, head: 1'b1};
                    n_out_valid  = 1'b1;
                    n_out_status = ST_OK;
                    n_out_off    = {r_best, MIN_ORDER'(0)} + 16'(HEADER_BYTES);
                    n_out_ord    = r_k;
                end
            end
            S_F_CHK: begin
                n_o     = r_rdata.order;
                n_first = r_rdata.order;
                if (!r_rdata.head || r_rdata.free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_BAD_FREE;
                end
            end
            S_F_MRG: begin
                rd_addr = buddy;
                n_b     = buddy;
            end
            S_F_BCHK: begin
                if (r_rdata.head && r_rdata.free && r_rdata.order == r_o) begin
                    // upper of the pair drops out, lower carries on
                    wr_en   = 1'b1;
                    wr_addr = (r_b < r_s[SLOT_W-1:0]) ? r_s[SLOT_W-1:0] : r_b;
                    wr_data = '0;
                    n_o     = r_o + 5'd1;
                    n_s     = (r_b < r_s[SLOT_W-1:0]) ? SCNT_W'(r_b) : r_s;
                end
            end
            S_F_FIN: begin
                wr_en        = 1'b1;
                wr_addr      = r_s[SLOT_W-1:0];
                wr_data      = '{order: r_o, free: 1'b1, head: 1'b1};
                n_out_valid  = 1'b1;
                n_out_status = ST_OK;
                n_out_off    = '0;
                n_out_ord    = r_first;
            end
            default: begin
            end
        endcase
        if (i_cfg_we) n_cnt = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_cnt          <= '0;
            r_region_order <= 5'(ORDER_LIMIT);
            r_out_valid    <= 1'b0;
            r_found        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_found     <= n_found;
            if (i_cfg_we) r_region_order <= clamp_order(i_cfg_wdata);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s          <= n_s;
        r_best       <= n_best;
        r_b          <= n_b;
        r_bord       <= n_bord;
        r_k          <= n_k;
        r_o          <= n_o;
        r_first      <= n_first;
        r_out_status <= n_out_status;
        r_out_off    <= n_out_off;
        r_out_ord    <= n_out_ord;
    end

    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> r_state == S_IDLE)
        else $error("request taken outside idle");

    a_no_pending_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_state != S_CLEAR) |-> !r_out_valid)
        else $error("work in progress with a response still pending");

    a_ok_order_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ST_OK) |->
        (r_out_ord >= 5'(MIN_ORDER) && r_out_ord <= r_region_order))
        else $error("granted order outside region");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !wr_en)
        else $error("slot write while idle");

endmodule

// ----- sv/bba_order_calc.sv -----
// smallest block order that holds a request plus its header
module bba_order_calc import bba_pkg::*; (
    input  logic [16:0] i_size_bytes,
    input  logic [4:0]  i_region_order,
    output logic [4:0]  o_order,
    output logic        o_fit
);
    logic [17:0] need;
    logic        found;

    assign need = 18'(i_size_bytes) + 18'(HEADER_BYTES);

    // downward walk so the lowest fitting order wins
    always_comb begin
        o_order = 5'(MIN_ORDER);
        found   = 1'b0;
        for (int j = ORDER_LIMIT; j >= MIN_ORDER; j--) begin
            if ((19'(1) << j) >= 19'(need) && 5'(j) <= i_region_order) begin
                o_order = 5'(j);
                found   = 1'b1;
            end
        end
        o_fit = found && (i_size_bytes != 17'd0);
    end
endmodule
